@@ hw/rtl/bfsa_pkg.sv @@
`timescale 1ns / 1ps
package bfsa_pkg;

   localparam int LEN_W   = 11;
   localparam int ADDR_W  = 10;
   localparam int CNT_W   = 9;
   localparam int OWN_W   = 16;
   localparam int STAT_W  = 2;
   localparam int DATA_W  = 32;
   localparam int PADDR_W = 3;

   localparam int DEF_MEM_UNITS    = 1024;
   localparam int DEF_MAX_SEGMENTS = 256;
   localparam int DEF_OWNER_BITS   = 16;

   localparam int RST_TOTAL_SIZE = 1024;
   localparam int RST_MIN_SPLIT  = 4;

   localparam logic REG_TOTAL_SIZE = 1'b0;
   localparam logic REG_MIN_SPLIT  = 1'b1;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_FIT    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_OWNER = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_WR_NEW,
      S_WR_BEST,
      S_COUNT,
      S_COMPACT,
      S_FLUSH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0] total_size;
      logic [LEN_W-1:0] min_split;
      logic             init;
   } csr_type;

endpackage

@@ hw/rtl/best_fit_segment_allocator.sv @@
`timescale 1ns / 1ps
// Best-fit segment allocator. The segment table lives in one RAM with a registered
// read; a sequencer streams it one entry per cycle. Allocate scans the table, then
// shifts entries when the winner is split, then writes back and answers. Free takes
// two passes over the table (one to count the owner's segments, one to release and
// merge them in place). After reset or a total_size write the table is rebuilt.
// A finished word waits in an output register.
module best_fit_segment_allocator #(
   parameter int MEM_UNITS    = bfsa_pkg::DEF_MEM_UNITS,
   parameter int MAX_SEGMENTS = bfsa_pkg::DEF_MAX_SEGMENTS,
   parameter int OWNER_BITS   = bfsa_pkg::DEF_OWNER_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [bfsa_pkg::LEN_W-1:0]    req_size,
   input  logic [bfsa_pkg::OWN_W-1:0]    req_owner,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bfsa_pkg::STAT_W-1:0]   rsp_status,
   output logic [bfsa_pkg::ADDR_W-1:0]   rsp_grant_addr,
   output logic [bfsa_pkg::LEN_W-1:0]    rsp_freed_units,
   output logic [bfsa_pkg::CNT_W-1:0]    rsp_freed_segments,
   output logic [bfsa_pkg::LEN_W-1:0]    rsp_used_units,
   output logic [bfsa_pkg::CNT_W-1:0]    rsp_owned_blocks,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bfsa_pkg::PADDR_W-1:0]  paddr,
   input  logic [bfsa_pkg::DATA_W-1:0]   pwdata,
   output logic [bfsa_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int EW = 2 * bfsa_pkg::LEN_W + 1 + OWNER_BITS;

   bfsa_pkg::csr_type csr;
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata, mem_rdata;

   bfsa_csr #(
      .MEM_UNITS(MEM_UNITS)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .csr    (csr)
   );

   bfsa_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_SEGMENTS)
   ) u_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   bfsa_core #(
      .MAX_SEGMENTS(MAX_SEGMENTS),
      .OWNER_BITS  (OWNER_BITS),
      .IW          (IW),
      .EW          (EW)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_size          (req_size),
      .req_owner         (req_owner),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_grant_addr    (rsp_grant_addr),
      .rsp_freed_units   (rsp_freed_units),
      .rsp_freed_segments(rsp_freed_segments),
      .rsp_used_units    (rsp_used_units),
      .rsp_owned_blocks  (rsp_owned_blocks),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata)
   );

endmodule

@@ hw/rtl/bfsa_ram.sv @@
`timescale 1ns / 1ps
module bfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/bfsa_csr.sv @@
`timescale 1ns / 1ps
module bfsa_csr #(
   parameter int MEM_UNITS = bfsa_pkg::DEF_MEM_UNITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bfsa_pkg::PADDR_W-1:0]  paddr,
   input  logic [bfsa_pkg::DATA_W-1:0]   pwdata,
   output logic [bfsa_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output bfsa_pkg::csr_type             csr
);

   localparam int LW = bfsa_pkg::LEN_W;
   localparam logic [LW-1:0] RST_TOTAL = LW'((MEM_UNITS < bfsa_pkg::RST_TOTAL_SIZE) ?
                                             MEM_UNITS : bfsa_pkg::RST_TOTAL_SIZE);

   logic [LW-1:0] total_ff, total_in;
   logic [LW-1:0] split_ff, split_in;
   logic          init_ff, init_in;
   logic          wr;
   logic [LW-1:0] v;

   assign wr     = psel & penable & pwrite;
   assign v      = pwdata[LW-1:0];
   assign pready = 1'b1;

   always_comb begin
      total_in = total_ff;
      split_in = split_ff;
      init_in  = 1'b0;
      if (wr) begin
         case (paddr[2])
            bfsa_pkg::REG_TOTAL_SIZE: begin
               init_in = 1'b1;
               if (v == '0) begin
                  total_in = LW'(1);
               end else if (32'(v) > 32'(MEM_UNITS)) begin
                  total_in = LW'(MEM_UNITS);
               end else begin
                  total_in = v;
               end
            end
            default: begin
               split_in = v;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= RST_TOTAL;
         split_ff <= LW'(bfsa_pkg::RST_MIN_SPLIT);
         init_ff  <= 1'b0;
      end else begin
         total_ff <= total_in;
         split_ff <= split_in;
         init_ff  <= init_in;
      end
   end

   assign prdata = (paddr[2] == bfsa_pkg::REG_TOTAL_SIZE) ?
                   bfsa_pkg::DATA_W'(total_ff) : bfsa_pkg::DATA_W'(split_ff);

   assign csr.total_size = total_ff;
   assign csr.min_split  = split_ff;
   assign csr.init       = init_ff;

endmodule

@@ hw/rtl/bfsa_core.sv @@
`timescale 1ns / 1ps
module bfsa_core #(
   parameter int MAX_SEGMENTS = bfsa_pkg::DEF_MAX_SEGMENTS,
   parameter int OWNER_BITS   = bfsa_pkg::DEF_OWNER_BITS,
   parameter int IW           = $clog2(MAX_SEGMENTS),
   parameter int EW           = 2 * bfsa_pkg::LEN_W + 1 + OWNER_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bfsa_pkg::csr_type            csr,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [bfsa_pkg::LEN_W-1:0]   req_size,
   input  logic [bfsa_pkg::OWN_W-1:0]   req_owner,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bfsa_pkg::STAT_W-1:0]  rsp_status,
   output logic [bfsa_pkg::ADDR_W-1:0]  rsp_grant_addr,
   output logic [bfsa_pkg::LEN_W-1:0]   rsp_freed_units,
   output logic [bfsa_pkg::CNT_W-1:0]   rsp_freed_segments,
   output logic [bfsa_pkg::LEN_W-1:0]   rsp_used_units,
   output logic [bfsa_pkg::CNT_W-1:0]   rsp_owned_blocks,
   output logic                         mem_we,
   output logic [IW-1:0]                mem_waddr,
   output logic [EW-1:0]                mem_wdata,
   output logic [IW-1:0]                mem_raddr,
   input  logic [EW-1:0]                mem_rdata
);

   localparam int LW = bfsa_pkg::LEN_W;
   localparam int OW = OWNER_BITS;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int B_LEN  = LW;
   localparam int B_BUSY = 2 * LW;
   localparam int B_OWN  = 2 * LW + 1;

   bfsa_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] used_ff, used_in;
   logic [CW-1:0] blocks_ff, blocks_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          pend_ff, pend_in;
   logic [LW-1:0] size_ff, size_in;
   logic [OW-1:0] owner_ff, owner_in;
   logic          found_ff, found_in;
   logic          split_ff, split_in;
   logic [IW-1:0] best_ff, best_in;
   logic [LW-1:0] slack_ff, slack_in;
   logic [LW-1:0] bstart_ff, bstart_in;
   logic [LW-1:0] blen_ff, blen_in;
   logic [IW-1:0] wr_addr_ff, wr_addr_in;
   logic [LW-1:0] freed_u_ff, freed_u_in;
   logic [CW-1:0] freed_s_ff, freed_s_in;
   logic [EW-1:0] hold_ff, hold_in;
   logic          hold_v_ff, hold_v_in;
   logic [IW-1:0] hw_ff, hw_in;
   logic [bfsa_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic [LW-1:0] grant_ff, grant_in;

   logic                         rv_ff, rv_in;
   logic [bfsa_pkg::STAT_W-1:0]  o_stat_ff, o_stat_in;
   logic [bfsa_pkg::ADDR_W-1:0]  o_grant_ff, o_grant_in;
   logic [LW-1:0]                o_fu_ff, o_fu_in;
   logic [bfsa_pkg::CNT_W-1:0]   o_fs_ff, o_fs_in;
   logic [LW-1:0]                o_used_ff, o_used_in;
   logic [bfsa_pkg::CNT_W-1:0]   o_blk_ff, o_blk_in;

   logic [LW-1:0] e_start, e_len, e_slack;
   logic          e_busy, e_match;
   logic [OW-1:0] e_owner;
   logic [EW-1:0] cur;
   logic          issue;

   assign e_start = mem_rdata[LW-1:0];
   assign e_len   = mem_rdata[B_LEN +: LW];
   assign e_busy  = mem_rdata[B_BUSY];
   assign e_owner = mem_rdata[B_OWN +: OW];
   assign e_slack = e_len - size_ff;
   assign e_match = e_busy && (e_owner == owner_ff);
   assign cur     = e_match ? {OW'(0), 1'b0, e_len, e_start} : mem_rdata;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      used_in    = used_ff;
      blocks_in  = blocks_ff;
      rd_idx_in  = rd_idx_ff;
      pend_in    = 1'b0;
      size_in    = size_ff;
      owner_in   = owner_ff;
      found_in   = found_ff;
      split_in   = split_ff;
      best_in    = best_ff;
      slack_in   = slack_ff;
      bstart_in  = bstart_ff;
      blen_in    = blen_ff;
      wr_addr_in = wr_addr_ff;
      freed_u_in = freed_u_ff;
      freed_s_in = freed_s_ff;
      hold_in    = hold_ff;
      hold_v_in  = hold_v_ff;
      hw_in      = hw_ff;
      stat_in    = stat_ff;
      grant_in   = grant_ff;
      rv_in      = rv_ff && rsp_stall;
      o_stat_in  = o_stat_ff;
      o_grant_in = o_grant_ff;
      o_fu_in    = o_fu_ff;
      o_fs_in    = o_fs_ff;
      o_used_in  = o_used_ff;
      o_blk_in   = o_blk_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      mem_raddr  = rd_idx_ff[IW-1:0];
      issue      = 1'b0;
      req_stall  = (state_ff != bfsa_pkg::S_IDLE) || csr.init;

      case (state_ff)
         bfsa_pkg::S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {OW'(0), 1'b0, csr.total_size, LW'(0)};
            count_in  = CW'(1);
            used_in   = '0;
            blocks_in = '0;
            state_in  = bfsa_pkg::S_IDLE;
         end
         bfsa_pkg::S_IDLE: begin
            if (csr.init) begin
               state_in = bfsa_pkg::S_INIT;
            end else if (req_valid) begin
               size_in    = req_size;
               owner_in   = OW'(req_owner);
               found_in   = 1'b0;
               freed_u_in = '0;
               freed_s_in = '0;
               grant_in   = '0;
               rd_idx_in  = '0;
               if (req_func == bfsa_pkg::FUNC_ALLOC) begin
                  if (req_size == '0) begin
                     stat_in  = bfsa_pkg::STAT_NO_FIT;
                     state_in = bfsa_pkg::S_DONE;
                  end else begin
                     state_in = bfsa_pkg::S_SCAN;
                  end
               end else if (OW'(req_owner) == '0) begin
                  stat_in  = bfsa_pkg::STAT_BAD_OWNER;
                  state_in = bfsa_pkg::S_DONE;
               end else begin
                  state_in = bfsa_pkg::S_COUNT;
               end
            end
         end
         bfsa_pkg::S_SCAN: begin
            issue = rd_idx_ff < count_ff;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff && !e_busy && e_len >= size_ff &&
                (!found_ff || e_slack < slack_ff)) begin
               found_in  = 1'b1;
               best_in   = IW'(rd_idx_ff - CW'(1));
               slack_in  = e_slack;
               bstart_in = e_start;
               blen_in   = e_len;
            end
            if (!issue && !pend_ff) begin
               if (!found_ff) begin
                  stat_in  = bfsa_pkg::STAT_NO_FIT;
                  state_in = bfsa_pkg::S_DONE;
               end else if (slack_ff != '0 && slack_ff >= csr.min_split &&
                            32'(count_ff) < 32'(MAX_SEGMENTS)) begin
                  split_in  = 1'b1;
                  rd_idx_in = count_ff;
                  state_in  = bfsa_pkg::S_SHIFT;
               end else begin
                  split_in = 1'b0;
                  state_in = bfsa_pkg::S_WR_BEST;
               end
            end
         end
         bfsa_pkg::S_SHIFT: begin
            issue     = rd_idx_ff > (CW'(best_ff) + CW'(1));
            mem_raddr = IW'(rd_idx_ff - CW'(1));
            if (issue) begin
               wr_addr_in = rd_idx_ff[IW-1:0];
               rd_idx_in  = rd_idx_ff - CW'(1);
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = mem_rdata;
            end
            if (!issue && !pend_ff) begin
               state_in = bfsa_pkg::S_WR_NEW;
            end
         end
         bfsa_pkg::S_WR_NEW: begin
            mem_we    = 1'b1;
            mem_waddr = best_ff + IW'(1);
            mem_wdata = {OW'(0), 1'b0, slack_ff, bstart_ff + size_ff};
            count_in  = count_ff + CW'(1);
            state_in  = bfsa_pkg::S_WR_BEST;
         end
         bfsa_pkg::S_WR_BEST: begin
            mem_we    = 1'b1;
            mem_waddr = best_ff;
            mem_wdata = {owner_ff, 1'b1, split_ff ? size_ff : blen_ff, bstart_ff};
            used_in   = used_ff + (split_ff ? size_ff : blen_ff);
            if (owner_ff != '0) begin
               blocks_in = blocks_ff + CW'(1);
            end
            grant_in = bstart_ff;
            stat_in  = bfsa_pkg::STAT_OK;
            state_in = bfsa_pkg::S_DONE;
         end
         bfsa_pkg::S_COUNT: begin
            issue = rd_idx_ff < count_ff;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff && e_match) begin
               freed_u_in = freed_u_ff + e_len;
               freed_s_in = freed_s_ff + CW'(1);
            end
            if (!issue && !pend_ff) begin
               if (freed_s_ff == '0) begin
                  stat_in  = bfsa_pkg::STAT_NOT_FOUND;
                  state_in = bfsa_pkg::S_DONE;
               end else begin
                  used_in   = (used_ff >= freed_u_ff) ? used_ff - freed_u_ff : '0;
                  blocks_in = (blocks_ff >= freed_s_ff) ? blocks_ff - freed_s_ff : '0;
                  rd_idx_in = '0;
                  hold_v_in = 1'b0;
                  hw_in     = '0;
                  state_in  = bfsa_pkg::S_COMPACT;
               end
            end
         end
         bfsa_pkg::S_COMPACT: begin
            issue = rd_idx_ff < count_ff;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (hold_v_ff && !hold_ff[B_BUSY] && !cur[B_BUSY]) begin
                  hold_in = {hold_ff[EW-1:B_BUSY], hold_ff[B_LEN +: LW] + e_len,
                             hold_ff[LW-1:0]};
               end else begin
                  if (hold_v_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = hw_ff;
                     mem_wdata = hold_ff;
                     hw_in     = hw_ff + IW'(1);
                  end
                  hold_in   = cur;
                  hold_v_in = 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = bfsa_pkg::S_FLUSH;
            end
         end
         bfsa_pkg::S_FLUSH: begin
            mem_we    = 1'b1;
            mem_waddr = hw_ff;
            mem_wdata = hold_ff;
            count_in  = CW'(hw_ff) + CW'(1);
            stat_in   = bfsa_pkg::STAT_OK;
            state_in  = bfsa_pkg::S_DONE;
         end
         bfsa_pkg::S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in      = 1'b1;
               o_stat_in  = stat_ff;
               o_grant_in = grant_ff[bfsa_pkg::ADDR_W-1:0];
               o_fu_in    = freed_u_ff;
               o_fs_in    = bfsa_pkg::CNT_W'(freed_s_ff);
               o_used_in  = used_ff;
               o_blk_in   = bfsa_pkg::CNT_W'(blocks_ff);
               state_in   = bfsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfsa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfsa_pkg::S_INIT;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      used_ff    <= used_in;
      blocks_ff  <= blocks_in;
      rd_idx_ff  <= rd_idx_in;
      size_ff    <= size_in;
      owner_ff   <= owner_in;
      found_ff   <= found_in;
      split_ff   <= split_in;
      best_ff    <= best_in;
      slack_ff   <= slack_in;
      bstart_ff  <= bstart_in;
      blen_ff    <= blen_in;
      wr_addr_ff <= wr_addr_in;
      freed_u_ff <= freed_u_in;
      freed_s_ff <= freed_s_in;
      hold_ff    <= hold_in;
      hold_v_ff  <= hold_v_in;
      hw_ff      <= hw_in;
      stat_ff    <= stat_in;
      grant_ff   <= grant_in;
      o_stat_ff  <= o_stat_in;
      o_grant_ff <= o_grant_in;
      o_fu_ff    <= o_fu_in;
      o_fs_ff    <= o_fs_in;
      o_used_ff  <= o_used_in;
      o_blk_ff   <= o_blk_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = o_stat_ff;
   assign rsp_grant_addr     = o_grant_ff;
   assign rsp_freed_units    = o_fu_ff;
   assign rsp_freed_segments = o_fs_ff;
   assign rsp_used_units     = o_used_ff;
   assign rsp_owned_blocks   = o_blk_ff;

endmodule
